// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the ordered list design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/oale_pkg.sv =====
// ----------------------------------------------------------------------------
// oale_pkg
// Types and constants for the ordered list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package oale_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int IN_W       = 32;
  localparam int POS_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_SEARCH = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESOLVE
  } state_t;

  // Broadcast to every cell during the execute cycle.
  typedef struct packed {
    logic                  ins_en;
    logic                  rem_en;
    logic                  search;
    logic                  read;
    logic [POS_W-1:0]      pos;
    logic [POS_W-1:0]      count;
    logic [VALUE_BITS-1:0] key;
  } cell_ctrl_t;

  // Reduced answer from the cell row.
  typedef struct packed {
    logic                  any_hit;
    logic [IDX_W-1:0]      first_idx;
    logic [VALUE_BITS-1:0] data;
  } collect_t;

endpackage

// ===== design/oale_cell.sv =====
// ----------------------------------------------------------------------------
// oale_cell
// One list slot: holds an entry, shifts with its neighbors, flags a hit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oale_cell import oale_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [POS_W-1:0]      index,
  input  cell_ctrl_t            ctrl,
  input  logic [VALUE_BITS-1:0] left_value,
  input  logic [VALUE_BITS-1:0] right_value,
  output logic [VALUE_BITS-1:0] entry,
  output logic                  hit
);

  logic [VALUE_BITS-1:0] entry_next;
  logic                  hit_next;

  always_comb begin
    entry_next = entry;
    if (ctrl.ins_en && (index > ctrl.pos)) begin
      entry_next = left_value;
    end else if (ctrl.ins_en && (index == ctrl.pos)) begin
      entry_next = ctrl.key;
    end else if (ctrl.rem_en && (index >= ctrl.pos)) begin
      entry_next = right_value;
    end
    hit_next = (index < ctrl.count) &&
               ((ctrl.search && (entry == ctrl.key)) ||
                (ctrl.read && (index == ctrl.pos)));
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      hit <= hit_next;
    end
  end

endmodule

// ===== design/oale_collect.sv =====
// ----------------------------------------------------------------------------
// oale_collect
// Reduce the row of hit flags to the first hit index and its entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oale_collect import oale_pkg::*; (
  input  logic [CAPACITY-1:0]   hits,
  input  logic [VALUE_BITS-1:0] entries [CAPACITY],
  output collect_t              result
);

  logic [CAPACITY-1:0] first_hot;

  // Isolate the lowest set hit bit.
  assign first_hot = hits & (~hits + CAPACITY'(1));

  always_comb begin
    result.any_hit   = |hits;
    result.first_idx = '0;
    result.data      = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      result.first_idx = result.first_idx | ({IDX_W{first_hot[i]}} & IDX_W'(i));
      result.data      = result.data | ({VALUE_BITS{first_hot[i]}} & entries[i]);
    end
  end

endmodule

// ===== design/ordered_array_list_engine.sv =====
// A command accepted in idle runs the execute and resolve states; done is registered
//   from resolve. No new command is taken while busy, which covers the execute cycle,
//   where the cell row shifts and compares, and the resolve cycle, where hits reduce.
// The receiver cannot stall: each result shows for one cycle with done high.
// Reset (rst, synchronous): empties the list and returns to idle; entry
//   contents are left undefined and are never read before they are written.
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// Ordered list of up to CAPACITY entries kept in a chain of shifting cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ordered_array_list_engine import oale_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       operation,
  input  logic [POS_W-1:0] position,
  input  logic [IN_W-1:0]  value,
  output logic             done,
  output logic [1:0]       status,
  output logic [IDX_W-1:0] found_position,
  output logic [IN_W-1:0]  read_value,
  output logic [POS_W-1:0] list_length
);

  // Control state.
  state_t state, state_next;
  logic [POS_W-1:0] count, count_next;

  // Captured command of the transaction in flight.
  op_t                   cmd_op;
  logic [POS_W-1:0]      cmd_pos;
  logic [VALUE_BITS-1:0] cmd_key;

  // Status decided in the execute cycle (search status waits for the hits).
  status_t status_pre, status_pre_next;

  cell_ctrl_t            ctrl;
  logic                  accept;
  logic                  exec;
  logic                  resolve;
  logic                  op_ok;

  logic [VALUE_BITS-1:0] cell_entry [CAPACITY];
  logic [CAPACITY-1:0]   cell_hit;
  collect_t              coll;

  status_t status_final;

  // --------------------------------------------------------------------------
  // Sequencer: idle -> execute -> resolve -> idle.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    exec       = 1'b0;
    resolve    = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        exec       = 1'b1;
        state_next = S_RESOLVE;
      end
      S_RESOLVE: begin
        resolve    = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign accept = start && !busy;

  // Capture the command; payload registers need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_op  <= op_t'(operation);
      cmd_pos <= position;
      cmd_key <= value[VALUE_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Range and capacity checks, length update (execute cycle).
  // --------------------------------------------------------------------------
  always_comb begin
    status_pre_next = ST_OK;
    count_next      = count;
    op_ok           = 1'b0;
    case (cmd_op)
      OP_CLEAR: begin
        count_next = '0;
      end
      OP_INSERT: begin
        if (cmd_pos > count) begin
          status_pre_next = ST_RANGE;
        end else if (count == POS_W'(CAPACITY)) begin
          status_pre_next = ST_FULL;
        end else begin
          op_ok      = 1'b1;
          count_next = count + POS_W'(1);
        end
      end
      OP_REMOVE: begin
        if (cmd_pos >= count) begin
          status_pre_next = ST_RANGE;
        end else begin
          op_ok      = 1'b1;
          count_next = count - POS_W'(1);
        end
      end
      OP_READ: begin
        if (cmd_pos >= count) begin
          status_pre_next = ST_RANGE;
        end
      end
      default: begin
        // Search settles its status later; unused codes change nothing.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status_pre <= status_pre_next;
    end
  end

  // Broadcast to the cell row; enables are live only in the execute cycle.
  always_comb begin
    ctrl.ins_en = exec && op_ok && (cmd_op == OP_INSERT);
    ctrl.rem_en = exec && op_ok && (cmd_op == OP_REMOVE);
    ctrl.search = exec && (cmd_op == OP_SEARCH);
    ctrl.read   = exec && (cmd_op == OP_READ);
    ctrl.pos    = cmd_pos;
    ctrl.count  = count;
    ctrl.key    = cmd_key;
  end

  // --------------------------------------------------------------------------
  // Cell row: each cell takes its left neighbor on insert, its right on remove.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_value;
    logic [VALUE_BITS-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_value = cmd_key;
    end else begin : g_left
      assign left_value = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_right
      assign right_value = cell_entry[i+1];
    end

    oale_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .index       (POS_W'(i)),
      .ctrl        (ctrl),
      .left_value  (left_value),
      .right_value (right_value),
      .entry       (cell_entry[i]),
      .hit         (cell_hit[i])
    );
  end

  oale_collect u_collect (
    .hits    (cell_hit),
    .entries (cell_entry),
    .result  (coll)
  );

  // --------------------------------------------------------------------------
  // Result register: load in the resolve cycle, strobe done for one cycle.
  // --------------------------------------------------------------------------
  always_comb begin
    status_final = status_pre;
    if (cmd_op == OP_SEARCH) begin
      status_final = coll.any_hit ? ST_OK : ST_MISSING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= resolve;
    end
  end

  always_ff @(posedge clk) begin
    if (resolve) begin
      status         <= status_final;
      found_position <= ((cmd_op == OP_SEARCH) && coll.any_hit) ? coll.first_idx : '0;
      read_value     <= ((cmd_op == OP_READ) && coll.any_hit) ? IN_W'(coll.data) : '0;
      list_length    <= count;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= POS_W'(CAPACITY))
  `ASSERT_NEXT(a_done_latency, clk, rst, accept, ##2 done)
  `ASSERT_IMPLIES(a_full_len, clk, rst, done && (status == ST_FULL), list_length == POS_W'(CAPACITY))
  `ASSERT_IMPLIES(a_found_ok, clk, rst, done && (found_position != '0), status == ST_OK)

endmodule
